// ===== hw/rtl/kdwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kdwm_pkg
// Shared types, constants and the sine table builder for the kiwi drive mixer.
// ----------------------------------------------------------------------------
package kdwm_pkg;

  // Heading in sixteenths of a degree
  localparam int QUARTER_TURN = 1440;
  localparam int FULL_TURN    = 4 * QUARTER_TURN;
  localparam int HEAD_BIAS    = 6 * FULL_TURN;          // makes any 16-bit heading positive
  localparam int RED_DIV      = FULL_TURN / 64;         // turn size after dropping 6 low bits
  localparam int RED_RECIP    = (1 << 16) / RED_DIV;    // floor reciprocal, Q16

  localparam int SIN_DEPTH    = QUARTER_TURN + 1;
  localparam int SIN_AW       = $clog2(SIN_DEPTH);

  localparam logic [63:0] ONE_Q30       = 64'd1073741824;
  localparam logic [63:0] HALF_Q30      = 64'd536870912;
  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [29:0] INV_SQRT3_Q30 = 30'd619925131;

  localparam logic [15:0] Q15_ONE  = 16'd32768;
  localparam logic [15:0] Q15_MAXP = 16'd32767;

  localparam int          NLANE      = 3;
  localparam int          QBITS      = 16;
  localparam int          DIV_STAGES = QBITS / 2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [15:0] x_cmd;
    logic signed [15:0] y_cmd;
    logic signed [15:0] turn_cmd;
    logic signed [15:0] heading;
    logic               field_mode;
  } kdwm_in_t;

  typedef struct packed {
    logic signed [15:0] wheel_a;
    logic signed [15:0] wheel_b;
    logic signed [15:0] wheel_c;
  } kdwm_out_t;

  typedef struct packed {
    logic [15:0] sin_q15;
    logic [15:0] cos_q15;
    logic [1:0]  quad;
  } kdwm_trig_t;

  typedef struct packed {
    logic [NLANE-1:0][31:0] mag;
    logic [NLANE-1:0]       neg;
    logic [31:0]            max_mag;
    logic                   norm;
  } kdwm_mix_t;

  typedef struct packed {
    logic [47:0]      rem;
    logic [31:0]      den;
    logic [QBITS-1:0] quo;
    logic             neg;
  } kdwm_lane_t;

  typedef logic [15:0] sin_tab_t [SIN_DEPTH];

  // Rounded quotient by one Taylor series divisor, highest term first
  function automatic logic [63:0] series_term(input logic [63:0] p, input int i);
    logic [63:0] q;
    case (i)
      0:       q = (p + 64'd55) / 64'd110;
      1:       q = (p + 64'd36) / 64'd72;
      2:       q = (p + 64'd21) / 64'd42;
      3:       q = (p + 64'd10) / 64'd20;
      default: q = (p + 64'd3) / 64'd6;
    endcase
    return q;
  endfunction

  // Sine of a quarter-turn offset, Q15 in [0, 32768], Taylor series in Q30
  function automatic logic [15:0] sine_q15(input logic [SIN_AW-1:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] b;
    logic [63:0] p;
    logic [63:0] s;
    x  = (64'(a) * PI_Q30 + 64'(QUARTER_TURN)) / 64'(2 * QUARTER_TURN);
    x2 = (x * x + HALF_Q30) >> 30;
    b  = ONE_Q30;
    for (int i = 0; i < 5; i++) begin
      p = (x2 * b + HALF_Q30) >> 30;
      b = ONE_Q30 - series_term(p, i);
    end
    s = (x * b + HALF_Q30) >> 30;
    return 16'((s + 64'd16384) >> 15);
  endfunction

  function automatic sin_tab_t build_sin_table();
    sin_tab_t tab;
    for (int i = 0; i < SIN_DEPTH; i++) begin
      tab[i] = sine_q15(SIN_AW'(i));
    end
    return tab;
  endfunction

endpackage

// ===== hw/rtl/kdwm_heading.sv =====
// ----------------------------------------------------------------------------
// kdwm_heading
// Reduces the heading to quadrant and offset, then looks up sine and cosine.
// ----------------------------------------------------------------------------
module kdwm_heading (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  kdwm_pkg::kdwm_in_t in_cmd,
  output logic               trig_valid,
  output kdwm_pkg::kdwm_in_t trig_cmd,
  output kdwm_pkg::kdwm_trig_t trig
);
  import kdwm_pkg::*;

  localparam sin_tab_t SIN_TABLE = build_sin_table();

  // Stage 1: heading modulo a full turn
  logic signed [17:0] hb_s;
  logic [16:0]        hb;
  logic [10:0]        hw;
  logic [19:0]        hq_prod;
  logic [3:0]         hq;
  logic [10:0]        hr0;
  logic [6:0]         hr1;
  logic [12:0]        hm_nxt;

  logic               v1_r;
  kdwm_in_t           cmd1_r;
  logic [12:0]        hm_r;

  always_comb begin
    hb_s    = 18'(in_cmd.heading) + 18'(HEAD_BIAS);
    hb      = hb_s[16:0];
    hw      = hb[16:6];
    hq_prod = 20'(hw) * 20'(RED_RECIP);
    hq      = hq_prod[19:16];
    hr0     = hw - 11'(hq * 11'(RED_DIV));
    // reciprocal is low by a hair: quotient may be one short
    if (hr0 >= 11'(RED_DIV)) begin
      hr1 = 7'(hr0 - 11'(RED_DIV));
    end else begin
      hr1 = 7'(hr0);
    end
    hm_nxt = {hr1, hb[5:0]};
  end

  // Stage 2: quadrant and offset
  logic [1:0]        quad_nxt;
  logic [SIN_AW-1:0] off_nxt;
  logic              v2_r;
  kdwm_in_t          cmd2_r;
  logic [1:0]        quad2_r;
  logic [SIN_AW-1:0] off_r;
  logic [SIN_AW-1:0] coff_r;

  always_comb begin
    priority if (hm_r >= 13'(3 * QUARTER_TURN)) begin
      quad_nxt = QUAD_3;
      off_nxt  = SIN_AW'(hm_r - 13'(3 * QUARTER_TURN));
    end else if (hm_r >= 13'(2 * QUARTER_TURN)) begin
      quad_nxt = QUAD_2;
      off_nxt  = SIN_AW'(hm_r - 13'(2 * QUARTER_TURN));
    end else if (hm_r >= 13'(QUARTER_TURN)) begin
      quad_nxt = QUAD_1;
      off_nxt  = SIN_AW'(hm_r - 13'(QUARTER_TURN));
    end else begin
      quad_nxt = QUAD_0;
      off_nxt  = SIN_AW'(hm_r);
    end
  end

  // Stage 3: table lookup
  logic        v3_r;
  kdwm_in_t    cmd3_r;
  logic [1:0]  quad3_r;
  logic [15:0] sin_r;
  logic [15:0] cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r  <= in_cmd;
    hm_r    <= hm_nxt;
    cmd2_r  <= cmd1_r;
    quad2_r <= quad_nxt;
    off_r   <= off_nxt;
    coff_r  <= SIN_AW'(QUARTER_TURN) - off_nxt;
    cmd3_r  <= cmd2_r;
    quad3_r <= quad2_r;
    sin_r   <= SIN_TABLE[off_r];
    cos_r   <= SIN_TABLE[coff_r];
  end

  assign trig_valid   = v3_r;
  assign trig_cmd     = cmd3_r;
  assign trig.sin_q15 = sin_r;
  assign trig.cos_q15 = cos_r;
  assign trig.quad    = quad3_r;

  a_hm_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> hm_r < 13'(FULL_TURN)) else $error("heading reduction out of range");
  a_off_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (off_r < SIN_AW'(QUARTER_TURN)) && (32'(off_r) + 32'(coff_r) == QUARTER_TURN))
    else $error("offset pair broken");
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (sin_r <= Q15_ONE) && (cos_r <= Q15_ONE)) else $error("table value too large");

endmodule

// ===== hw/rtl/kdwm_mixer.sv =====
// ----------------------------------------------------------------------------
// kdwm_mixer
// Rotates the command, mixes it into three wheel drives, finds the largest.
// ----------------------------------------------------------------------------
module kdwm_mixer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 trig_valid,
  input  kdwm_pkg::kdwm_in_t   trig_cmd,
  input  kdwm_pkg::kdwm_trig_t trig,
  output logic                 mix_valid,
  output kdwm_pkg::kdwm_mix_t  mix
);
  import kdwm_pkg::*;

  logic [4:0] v_r;

  // Stage 4: quadrant signs and rotation products
  logic signed [16:0] sa;
  logic signed [16:0] ca;
  logic signed [16:0] sn;
  logic signed [16:0] cs;
  logic signed [32:0] pxc_r;
  logic signed [32:0] pys_r;
  logic signed [32:0] pxs_r;
  logic signed [32:0] pyc_r;
  logic signed [15:0] t4_r;

  always_comb begin
    sa = signed'({1'b0, trig.sin_q15});
    ca = signed'({1'b0, trig.cos_q15});
    unique case (trig.quad)
      QUAD_0: begin sn = sa;  cs = ca;  end
      QUAD_1: begin sn = ca;  cs = -sa; end
      QUAD_2: begin sn = -sa; cs = -ca; end
      QUAD_3: begin sn = -ca; cs = sa;  end
      default: begin sn = sa; cs = ca;  end
    endcase
    // robot frame: identity rotation
    if (!trig_cmd.field_mode) begin
      sn = 17'sd0;
      cs = 17'sd32768;
    end
  end

  // Stage 5: rotated command and mix sums
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [33:0] tq;
  logic signed [34:0] s1_r;
  logic signed [34:0] s2_r;
  logic signed [33:0] yr5_r;

  always_comb begin
    xr = 34'(pxc_r) - 34'(pys_r);
    yr = 34'(pxs_r) + 34'(pyc_r);
    tq = {{3{t4_r[15]}}, t4_r, 15'd0};
  end

  // Stage 6: scale by 1/sqrt3 on magnitudes
  logic [31:0]        m1;
  logic [32:0]        m2;
  logic [61:0]        p1_r;
  logic [62:0]        p2_r;
  logic               n1_r;
  logic               n2_r;
  logic signed [33:0] yr6_r;
  logic signed [34:0] s1_abs;
  logic signed [34:0] s2_abs;

  always_comb begin
    s1_abs = s1_r[34] ? -s1_r : s1_r;
    s2_abs = s2_r[34] ? -s2_r : s2_r;
    m1     = s1_abs[31:0];
    m2     = s2_abs[32:0];
  end

  // Stage 7: round and form wheel drives
  logic [31:0]        r1;
  logic [31:0]        r2;
  logic [62:0]        r2_full;
  logic [61:0]        r1_full;
  logic signed [33:0] sum;
  logic signed [33:0] wc;
  logic signed [33:0] wa_r;
  logic signed [33:0] wb_r;
  logic signed [33:0] wc_r;

  always_comb begin
    r1_full = (p1_r + 62'(HALF_Q30)) >> 30;
    r2_full = (p2_r + 63'(HALF_Q30)) >> 30;
    r1      = r1_full[31:0];
    r2      = r2_full[31:0];
    sum     = n1_r ? -signed'({2'b00, r1}) : signed'({2'b00, r1});
    wc      = n2_r ? -signed'({2'b00, r2}) : signed'({2'b00, r2});
  end

  // Stage 8: magnitudes, largest, normalize flag
  logic [NLANE-1:0][31:0] mag;
  logic [NLANE-1:0]       neg;
  logic signed [33:0]     w_abs [NLANE];
  logic signed [33:0]     w_all [NLANE];
  logic [31:0]            mx_ab;
  logic [31:0]            mx;
  kdwm_mix_t              mix_r;

  always_comb begin
    w_all[0] = wa_r;
    w_all[1] = wb_r;
    w_all[2] = wc_r;
    for (int l = 0; l < NLANE; l++) begin
      w_abs[l] = w_all[l][33] ? -w_all[l] : w_all[l];
      mag[l]   = w_abs[l][31:0];
      neg[l]   = w_all[l][33];
    end
    mx_ab = (mag[1] > mag[0]) ? mag[1] : mag[0];
    mx    = (mag[2] > mx_ab) ? mag[2] : mx_ab;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], trig_valid};
    end
  end

  always_ff @(posedge clk) begin
    pxc_r <= 33'(trig_cmd.x_cmd) * 33'(cs);
    pys_r <= 33'(trig_cmd.y_cmd) * 33'(sn);
    pxs_r <= 33'(trig_cmd.x_cmd) * 33'(sn);
    pyc_r <= 33'(trig_cmd.y_cmd) * 33'(cs);
    t4_r  <= trig_cmd.turn_cmd;

    s1_r  <= 35'(tq) + 35'(xr);
    s2_r  <= (35'(xr) <<< 1) - 35'(tq);
    yr5_r <= yr;

    p1_r  <= 62'(m1) * 62'(INV_SQRT3_Q30);
    p2_r  <= 63'(m2) * 63'(INV_SQRT3_Q30);
    n1_r  <= s1_r[34];
    n2_r  <= s2_r[34];
    yr6_r <= yr5_r;

    wa_r  <= -sum - yr6_r;
    wb_r  <= -sum + yr6_r;
    wc_r  <= wc;

    mix_r.mag     <= mag;
    mix_r.neg     <= neg;
    mix_r.max_mag <= mx;
    mix_r.norm    <= 64'(mx) > ONE_Q30;
  end

  assign mix_valid = v_r[4];
  assign mix       = mix_r;

  a_max_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (mix_r.mag[0] <= mix_r.max_mag) && (mix_r.mag[1] <= mix_r.max_mag)
               && (mix_r.mag[2] <= mix_r.max_mag)) else $error("largest drive below a lane");
  a_max_is_lane: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (mix_r.mag[0] == mix_r.max_mag) || (mix_r.mag[1] == mix_r.max_mag)
               || (mix_r.mag[2] == mix_r.max_mag)) else $error("largest drive not a lane");

endmodule

// ===== hw/rtl/kdwm_norm_div.sv =====
// ----------------------------------------------------------------------------
// kdwm_norm_div
// Pipelined restoring divider, two quotient bits per stage, three lanes.
// Scales drives to Q15 by the largest magnitude, or plainly, then saturates.
// ----------------------------------------------------------------------------
module kdwm_norm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mix_valid,
  input  kdwm_pkg::kdwm_mix_t mix,
  output logic                out_valid,
  output kdwm_pkg::kdwm_out_t out_data
);
  import kdwm_pkg::*;

  function automatic kdwm_lane_t div_step(input kdwm_lane_t ln, input int bitpos);
    logic [48:0] diff;
    kdwm_lane_t  res;
    res  = ln;
    diff = {1'b0, ln.rem} - (49'(ln.den) << bitpos);
    if (!diff[48]) begin
      res.rem         = diff[47:0];
      res.quo[bitpos] = 1'b1;
    end
    return res;
  endfunction

  kdwm_lane_t             st_r  [DIV_STAGES+1][NLANE];
  kdwm_lane_t             st_nxt[DIV_STAGES+1][NLANE];
  logic [DIV_STAGES:0]    v_r;
  logic                   vo_r;
  kdwm_out_t              out_r;
  logic signed [15:0]     wheel [NLANE];
  logic [QBITS-1:0]       qf;

  // Prep: either u*2^15 + m/2 over m, or u + 2^14 over 2^15
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      st_nxt[0][l].quo = '0;
      st_nxt[0][l].neg = mix.neg[l];
      if (mix.norm) begin
        st_nxt[0][l].rem = 48'({mix.mag[l], 15'd0}) + 48'(mix.max_mag >> 1);
        st_nxt[0][l].den = mix.max_mag;
      end else begin
        st_nxt[0][l].rem = 48'(mix.mag[l]) + 48'd16384;
        st_nxt[0][l].den = 32'(Q15_ONE);
      end
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        st_nxt[s+1][l] = div_step(div_step(st_r[s][l], QBITS - 1 - 2 * s),
                                  QBITS - 2 - 2 * s);
      end
    end
  end

  // Saturate the quotient to signed Q15
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      qf = st_r[DIV_STAGES][l].quo;
      if (st_r[DIV_STAGES][l].neg) begin
        wheel[l] = (qf > Q15_ONE) ? signed'(Q15_ONE) : signed'(-qf);
      end else begin
        wheel[l] = (qf > 16'(Q15_MAXP)) ? signed'(Q15_MAXP) : signed'(qf);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[DIV_STAGES-1:0], mix_valid};
      vo_r <= v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= DIV_STAGES; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        st_r[s][l] <= st_nxt[s][l];
      end
    end
    out_r.wheel_a <= wheel[0];
    out_r.wheel_b <= wheel[1];
    out_r.wheel_c <= wheel[2];
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STAGES] |-> (st_r[DIV_STAGES][0].quo <= Q15_ONE)
      && (st_r[DIV_STAGES][1].quo <= Q15_ONE) && (st_r[DIV_STAGES][2].quo <= Q15_ONE))
    else $error("normalized drive above full scale");
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STAGES] |-> (st_r[DIV_STAGES][0].rem < 48'(st_r[DIV_STAGES][0].den))
      && (st_r[DIV_STAGES][2].rem < 48'(st_r[DIV_STAGES][2].den)))
    else $error("division left a remainder above the divisor");

endmodule

// ===== hw/rtl/kiwi_drive_wheel_mixer_top.sv =====
// ----------------------------------------------------------------------------
// kiwi_drive_wheel_mixer_top
// Inverse kinematics for a three-wheel omni base, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data with one command (x, y, turn, heading, field_mode) and pulse
//   start. busy is always low, so every cycle with start high is a transfer.
//   When field_mode is set, (x, y) is rotated by the heading before mixing.
//   Each command gives one result: out_valid is high for one cycle with the
//   three wheel drives on out_data.
//   Throughput is one command per cycle; the pipeline is a heading and sine
//   table front end (3 stages), the rotate and mix datapath (5 stages) and a
//   two-bits-per-stage normalizing divider with saturation (10 stages).
//   Reset clears the valid bits of all stages; results in flight are dropped.
//   The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
module kiwi_drive_wheel_mixer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kdwm_pkg::kdwm_in_t  in_data,
  output logic                out_valid,
  output kdwm_pkg::kdwm_out_t out_data
);
  import kdwm_pkg::*;

  localparam int LATENCY = 3 + 5 + DIV_STAGES + 2;

  logic       in_xfer;
  logic       trig_valid;
  kdwm_in_t   trig_cmd;
  kdwm_trig_t trig;
  logic       mix_valid;
  kdwm_mix_t  mix;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  kdwm_heading u_heading (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .in_cmd     (in_data),
    .trig_valid (trig_valid),
    .trig_cmd   (trig_cmd),
    .trig       (trig)
  );

  kdwm_mixer u_mixer (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .trig_cmd   (trig_cmd),
    .trig       (trig),
    .mix_valid  (mix_valid),
    .mix        (mix)
  );

  kdwm_norm_div u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (mix_valid),
    .mix       (mix),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, LATENCY)) else $error("result without a command");

endmodule
